>>> rtl/sllt_pkg.sv
// ----------------------------------------------------------------------------
// sllt_pkg
// Shared types and constants for the split L1 cache tracker: payload
// structs, per-way tag/state rows and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package sllt_pkg;

  localparam int SET_COUNT    = 16384;
  localparam int LINE_BYTES   = 64;
  localparam int DATA_WAYS_N  = 4;
  localparam int INSTR_WAYS_N = 2;

  localparam int ADDR_W  = 32;
  localparam int CNT_W   = 32;
  localparam int LINE_W  = $clog2(LINE_BYTES);
  localparam int TAG_W   = ADDR_W - LINE_W;
  localparam int SET_W   = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int DWAY_W  = (DATA_WAYS_N > 1) ? $clog2(DATA_WAYS_N) : 1;
  localparam int IWAY_W  = (INSTR_WAYS_N > 1) ? $clog2(INSTR_WAYS_N) : 1;
  localparam int DRANK_W = DWAY_W;
  localparam int IRANK_W = IWAY_W;

  // Command codes
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_FETCH = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]        command;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic              hit;
    logic              l2_read;
    logic              writeback;
    logic [ADDR_W-1:0] writeback_address;
    logic [CNT_W-1:0]  data_hits;
    logic [CNT_W-1:0]  data_misses;
    logic [CNT_W-1:0]  data_reads;
    logic [CNT_W-1:0]  data_writes;
    logic [CNT_W-1:0]  instr_hits;
    logic [CNT_W-1:0]  instr_misses;
    logic [CNT_W-1:0]  instr_reads;
  } rsp_t;

  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic [DRANK_W-1:0] rank;
    logic [TAG_W-1:0]   tag;
  } dway_t;

  typedef struct packed {
    logic               valid;
    logic [IRANK_W-1:0] rank;
    logic [TAG_W-1:0]   tag;
  } iway_t;

  typedef dway_t [DATA_WAYS_N-1:0]  drow_t;
  typedef iway_t [INSTR_WAYS_N-1:0] irow_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture transaction, read both tag rows
    logic finish;  // update row, counters and result register
    logic sweep;   // zero one set of both caches
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rsp_busy;    // result register full and stalled
    logic is_clear;    // held transaction is a clear
    logic sweep_last;  // sweep index at the final set
  } ctrl_sts_t;

endpackage

>>> rtl/split_l1_lru_cache_tracker.sv
// ----------------------------------------------------------------------------
// split_l1_lru_cache_tracker
// Tag-only tracker of a 4-way data L1 and a 2-way instruction L1 with LRU,
// write-back/write-allocate, hit/miss/writeback reporting and counters.
// ----------------------------------------------------------------------------
//  channel | signals                   | payload
//  --------+---------------------------+--------------------------------
//  request | req_valid / req_stall     | req : command, address
//  result  | rsp_valid / rsp_stall     | rsp : flags, victim, counters
//
//  A transaction reads the set's row from the tag memories when it is
//  accepted, then updates the row, counters and the result register.
//  After reset and after a clear, the set sweep zeroes one set per cycle;
//  req_stall stays high until all SET_COUNT (16384) sets are zeroed.
//  A stalled result holds the next transaction in its update cycle.
// ----------------------------------------------------------------------------
module split_l1_lru_cache_tracker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  sllt_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output sllt_pkg::rsp_t rsp
);
  import sllt_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  sllt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  sllt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // No transaction taken while sets are being zeroed
  a_sweep_blocks: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep |-> req_stall) else $error("request taken during sweep");

  // Result register is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(rsp_valid && rsp_stall)) else $error("result overwritten");

  // An accepted transaction keeps the input closed the next cycle
  a_two_cycles: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall) else $error("back-to-back accept");

  // A hit never fetches from L2 or evicts
  a_hit_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.hit) |-> (!rsp.l2_read && !rsp.writeback))
    else $error("hit with miss side effects");

endmodule

>>> rtl/sllt_ctrl.sv
// ----------------------------------------------------------------------------
// sllt_ctrl
// Sequencer: set sweep, idle/accept, lookup-and-update.
// ----------------------------------------------------------------------------
module sllt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  sllt_pkg::ctrl_sts_t sts,
  output sllt_pkg::ctrl_cmd_t cmd
);
  import sllt_pkg::*;

  typedef enum logic [2:0] {
    ST_SWEEP = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_t;

  state_t state, state_next;

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = 1'b1;
    case (state)
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // Take the transaction; a stalled result only holds the update
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (!sts.rsp_busy) begin
          cmd.finish = 1'b1;
          state_next = sts.is_clear ? ST_SWEEP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

endmodule

>>> rtl/sllt_datapath.sv
// ----------------------------------------------------------------------------
// sllt_datapath
// Tag/state memories (one row per set), hit and victim selection, LRU rank
// update, event counters and the result register.
// ----------------------------------------------------------------------------
module sllt_datapath (
  input  logic                clk,
  input  logic                rst,
  input  sllt_pkg::req_t      req,
  input  sllt_pkg::ctrl_cmd_t cmd,
  output sllt_pkg::ctrl_sts_t sts,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output sllt_pkg::rsp_t      rsp
);
  import sllt_pkg::*;

  drow_t dmem [SET_COUNT];
  irow_t imem [SET_COUNT];

  req_t             held;
  drow_t            drd;
  irow_t            ird;
  logic [SET_W-1:0] sweep_idx;
  logic [CNT_W-1:0] cnt_dhit, cnt_dmiss, cnt_drd, cnt_dwr;
  logic [CNT_W-1:0] cnt_ihit, cnt_imiss, cnt_ird;

  logic [TAG_W-1:0] line_tag;
  logic [SET_W-1:0] req_set, held_set;
  logic             is_data, is_write, is_fetch, is_clear;

  assign line_tag = held.address[ADDR_W-1:LINE_W];
  assign req_set  = req.address[LINE_W +: SET_W];
  assign held_set = held.address[LINE_W +: SET_W];
  assign is_write = (held.command == CMD_WRITE);
  assign is_data  = (held.command == CMD_READ) || is_write;
  assign is_fetch = (held.command == CMD_FETCH);
  assign is_clear = (held.command == CMD_CLEAR);

  // Data cache: hit, victim and new row
  logic              d_hit, d_inv_found, d_wb;
  logic [DWAY_W-1:0] d_hw, d_iw, d_lw, d_sel;
  logic [DRANK_W-1:0] d_best;
  logic [DRANK_W:0]  d_limit;
  drow_t             d_new;
  always_comb begin
    d_hit = 1'b0; d_hw = '0; d_inv_found = 1'b0; d_iw = '0;
    d_lw = '0; d_best = '0;
    for (int w = DATA_WAYS_N - 1; w >= 0; w--) begin
      if (drd[w].valid && drd[w].tag == line_tag) begin
        d_hit = 1'b1; d_hw = DWAY_W'(w);
      end
      if (!drd[w].valid) begin
        d_inv_found = 1'b1; d_iw = DWAY_W'(w);
      end
    end
    for (int w = 0; w < DATA_WAYS_N; w++) begin
      if (w == 0 || drd[w].rank > d_best) begin
        d_best = drd[w].rank; d_lw = DWAY_W'(w);
      end
    end
    d_sel   = d_hit ? d_hw : (d_inv_found ? d_iw : d_lw);
    d_limit = drd[d_sel].valid ? {1'b0, drd[d_sel].rank} : (DRANK_W+1)'(DATA_WAYS_N);
    d_wb    = !d_hit && !d_inv_found && drd[d_sel].dirty;
    d_new   = drd;
    for (int w = 0; w < DATA_WAYS_N; w++) begin
      if (DWAY_W'(w) != d_sel && drd[w].valid && {1'b0, drd[w].rank} < d_limit) begin
        d_new[w].rank = drd[w].rank + 1'b1;
      end
    end
    d_new[d_sel].rank  = '0;
    d_new[d_sel].valid = 1'b1;
    d_new[d_sel].tag   = line_tag;
    d_new[d_sel].dirty = d_hit ? (drd[d_sel].dirty | is_write) : is_write;
  end

  // Instruction cache: hit, victim and new row
  logic               i_hit, i_inv_found;
  logic [IWAY_W-1:0]  i_hw, i_iw, i_lw, i_sel;
  logic [IRANK_W-1:0] i_best;
  logic [IRANK_W:0]   i_limit;
  irow_t              i_new;
  always_comb begin
    i_hit = 1'b0; i_hw = '0; i_inv_found = 1'b0; i_iw = '0;
    i_lw = '0; i_best = '0;
    for (int w = INSTR_WAYS_N - 1; w >= 0; w--) begin
      if (ird[w].valid && ird[w].tag == line_tag) begin
        i_hit = 1'b1; i_hw = IWAY_W'(w);
      end
      if (!ird[w].valid) begin
        i_inv_found = 1'b1; i_iw = IWAY_W'(w);
      end
    end
    for (int w = 0; w < INSTR_WAYS_N; w++) begin
      if (w == 0 || ird[w].rank > i_best) begin
        i_best = ird[w].rank; i_lw = IWAY_W'(w);
      end
    end
    i_sel   = i_hit ? i_hw : (i_inv_found ? i_iw : i_lw);
    i_limit = ird[i_sel].valid ? {1'b0, ird[i_sel].rank} : (IRANK_W+1)'(INSTR_WAYS_N);
    i_new   = ird;
    for (int w = 0; w < INSTR_WAYS_N; w++) begin
      if (IWAY_W'(w) != i_sel && ird[w].valid && {1'b0, ird[w].rank} < i_limit) begin
        i_new[w].rank = ird[w].rank + 1'b1;
      end
    end
    i_new[i_sel].rank  = '0;
    i_new[i_sel].valid = 1'b1;
    i_new[i_sel].tag   = line_tag;
  end

  // Memories: read on load, write on finish or sweep
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      held <= req;
      drd  <= dmem[req_set];
      ird  <= imem[req_set];
    end
    if (cmd.sweep) begin
      dmem[sweep_idx] <= '0;
      imem[sweep_idx] <= '0;
    end else if (cmd.finish && is_data) begin
      dmem[held_set] <= d_new;
    end else if (cmd.finish && is_fetch) begin
      imem[held_set] <= i_new;
    end
  end

  // Advance the sweep index
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx <= '0;
    end else if (cmd.sweep) begin
      sweep_idx <= sts.sweep_last ? '0 : sweep_idx + 1'b1;
    end
  end

  // Event counters
  always_ff @(posedge clk) begin
    if (rst || (cmd.finish && is_clear)) begin
      cnt_dhit <= '0; cnt_dmiss <= '0; cnt_drd <= '0; cnt_dwr <= '0;
      cnt_ihit <= '0; cnt_imiss <= '0; cnt_ird <= '0;
    end else if (cmd.finish && is_data) begin
      if (d_hit) cnt_dhit  <= cnt_dhit + 1'b1;
      else       cnt_dmiss <= cnt_dmiss + 1'b1;
      if (is_write) cnt_dwr <= cnt_dwr + 1'b1;
      else          cnt_drd <= cnt_drd + 1'b1;
    end else if (cmd.finish && is_fetch) begin
      if (i_hit) cnt_ihit  <= cnt_ihit + 1'b1;
      else       cnt_imiss <= cnt_imiss + 1'b1;
      cnt_ird <= cnt_ird + 1'b1;
    end
  end

  // Result payload as it will stand after this transaction
  rsp_t rsp_next;
  always_comb begin
    rsp_next = '0;
    if (is_data) begin
      rsp_next.hit       = d_hit;
      rsp_next.l2_read   = !d_hit && !is_write;
      rsp_next.writeback = d_wb;
      rsp_next.writeback_address = d_wb ?
          {drd[d_sel].tag, {LINE_W{1'b0}}} : '0;
      rsp_next.data_hits   = cnt_dhit + ADDR_W'(d_hit);
      rsp_next.data_misses = cnt_dmiss + ADDR_W'(!d_hit);
      rsp_next.data_reads  = cnt_drd + ADDR_W'(!is_write);
      rsp_next.data_writes = cnt_dwr + ADDR_W'(is_write);
      rsp_next.instr_hits   = cnt_ihit;
      rsp_next.instr_misses = cnt_imiss;
      rsp_next.instr_reads  = cnt_ird;
    end else if (is_fetch) begin
      rsp_next.hit     = i_hit;
      rsp_next.l2_read = !i_hit;
      rsp_next.data_hits   = cnt_dhit;
      rsp_next.data_misses = cnt_dmiss;
      rsp_next.data_reads  = cnt_drd;
      rsp_next.data_writes = cnt_dwr;
      rsp_next.instr_hits   = cnt_ihit + ADDR_W'(i_hit);
      rsp_next.instr_misses = cnt_imiss + ADDR_W'(!i_hit);
      rsp_next.instr_reads  = cnt_ird + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp <= rsp_next;
    end
  end

  assign sts.rsp_busy   = rsp_valid && rsp_stall;
  assign sts.is_clear   = is_clear;
  assign sts.sweep_last = (sweep_idx == SET_W'(SET_COUNT - 1));

endmodule

>>> dv/split_l1_lru_cache_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// split_l1_lru_cache_tracker_tb
// Self-checking bench for the split L1 tracker. A tag-level LRU model of both
// caches predicts each result. Directed cases come first, then random traffic
// concentrated on a few sets to force hits, evictions and dirty writebacks,
// under several sender/receiver idle mixes and a long receiver hold-off.
// ----------------------------------------------------------------------------
module split_l1_lru_cache_tracker_tb;
  import sllt_pkg::*;

  localparam int DCACHE = 0;
  localparam int ICACHE = 1;
  localparam int ENTRIES = SET_COUNT * DATA_WAYS_N;

  // Event counter slots
  localparam int CNT_DHITS   = 0;
  localparam int CNT_DMISS   = 1;
  localparam int CNT_DREADS  = 2;
  localparam int CNT_DWRITES = 3;
  localparam int CNT_IHITS   = 4;
  localparam int CNT_IMISS   = 5;
  localparam int CNT_IREADS  = 6;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  split_l1_lru_cache_tracker dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // Shadow tag state of both caches, indexed [cache][set*ways+way]
  bit [TAG_W-1:0] shadow_tag[2][ENTRIES];
  bit shadow_valid[2][ENTRIES];
  bit shadow_dirty[2][ENTRIES];
  int unsigned shadow_rank[2][ENTRIES];
  bit [CNT_W-1:0] ev_count[7];

  rsp_t expected_rsp[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  bit [11:0] tag_hi_pool[6];
  bit [SET_W-1:0] set_pool[3];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Invalidate both caches and zero the event counters
  function automatic void model_clear();
    for (int c = 0; c < 2; c++)
      for (int i = 0; i < ENTRIES; i++) begin
        shadow_valid[c][i] = 1'b0;
        shadow_dirty[c][i] = 1'b0;
        shadow_rank[c][i] = 0;
      end
    for (int k = 0; k < 7; k++) ev_count[k] = '0;
  endfunction

  // Move one way to rank 0, aging the valid ways that were more recent
  function automatic void lru_touch(int c, int base, int ways, int w);
    int unsigned limit;
    limit = shadow_valid[c][base+w] ? shadow_rank[c][base+w] : ways;
    for (int v = 0; v < ways; v++)
      if (v != w && shadow_valid[c][base+v] && shadow_rank[c][base+v] < limit)
        shadow_rank[c][base+v]++;
    shadow_rank[c][base+w] = 0;
  endfunction

  // Look up one cache; allocate on miss and report any dirty victim
  function automatic bit cache_lookup(int c, bit [ADDR_W-1:0] addr, bit is_write,
                                      output bit wb, output bit [ADDR_W-1:0] wb_addr);
    bit [TAG_W-1:0] line;
    int ways;
    int base;
    int victim;
    int unsigned best;
    bit found_invalid;
    line = addr[ADDR_W-1:LINE_W];
    ways = (c == DCACHE) ? DATA_WAYS_N : INSTR_WAYS_N;
    base = (line % SET_COUNT) * ways;
    victim = 0;
    best = 0;
    found_invalid = 1'b0;
    wb = 1'b0;
    wb_addr = '0;
    for (int w = 0; w < ways; w++)
      if (shadow_valid[c][base+w] && shadow_tag[c][base+w] == line) begin
        if (is_write) shadow_dirty[c][base+w] = 1'b1;
        lru_touch(c, base, ways, w);
        return 1'b1;
      end
    for (int w = 0; w < ways; w++) begin
      if (!shadow_valid[c][base+w]) begin
        victim = w;
        found_invalid = 1'b1;
        break;
      end
      if (w == 0 || shadow_rank[c][base+w] > best) begin
        best = shadow_rank[c][base+w];
        victim = w;
      end
    end
    if (!found_invalid && shadow_dirty[c][base+victim]) begin
      wb = 1'b1;
      wb_addr = {shadow_tag[c][base+victim], {LINE_W{1'b0}}};
    end
    lru_touch(c, base, ways, victim);
    shadow_valid[c][base+victim] = 1'b1;
    shadow_dirty[c][base+victim] = is_write;
    shadow_tag[c][base+victim] = line;
    return 1'b0;
  endfunction

  // Compute the result of one accepted transaction
  function automatic rsp_t predict_result(req_t r);
    rsp_t e;
    bit wb;
    bit [ADDR_W-1:0] wba;
    e = '0;
    wb = 1'b0;
    wba = '0;
    case (r.command)
      CMD_READ, CMD_WRITE: begin
        e.hit = cache_lookup(DCACHE, r.address, r.command == CMD_WRITE, wb, wba);
        if (e.hit) ev_count[CNT_DHITS]++;
        else ev_count[CNT_DMISS]++;
        if (r.command == CMD_WRITE) ev_count[CNT_DWRITES]++;
        else ev_count[CNT_DREADS]++;
        e.l2_read = !e.hit && r.command == CMD_READ;
      end
      CMD_FETCH: begin
        e.hit = cache_lookup(ICACHE, r.address, 1'b0, wb, wba);
        if (e.hit) ev_count[CNT_IHITS]++;
        else ev_count[CNT_IMISS]++;
        ev_count[CNT_IREADS]++;
        e.l2_read = !e.hit;
      end
      default: model_clear();
    endcase
    e.writeback = wb;
    e.writeback_address = wb ? wba : '0;
    e.data_hits = ev_count[CNT_DHITS];
    e.data_misses = ev_count[CNT_DMISS];
    e.data_reads = ev_count[CNT_DREADS];
    e.data_writes = ev_count[CNT_DWRITES];
    e.instr_hits = ev_count[CNT_IHITS];
    e.instr_misses = ev_count[CNT_IMISS];
    e.instr_reads = ev_count[CNT_IREADS];
    return e;
  endfunction

  // Offer one transaction, hold it until accepted, then record its result
  task automatic send_req(logic [1:0] cmd, logic [ADDR_W-1:0] addr);
    req_t r;
    r.command = cmd;
    r.address = addr;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (req_stall);
    expected_rsp = {expected_rsp, predict_result(r)};
  endtask

  task automatic go_idle();
    req_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    go_idle();
    wait (expected_rsp.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // Address in a hot set with one of a few tags, or fully random
  function automatic logic [ADDR_W-1:0] pick_addr();
    logic [ADDR_W-1:0] a;
    if ($urandom_range(99) < 20) return $urandom;
    a = {tag_hi_pool[$urandom_range(5)], set_pool[$urandom_range(2)], 6'd0};
    a[LINE_W-1:0] = LINE_W'($urandom);
    return a;
  endfunction

  function automatic logic [1:0] pick_cmd();
    int p;
    p = $urandom_range(999);
    if (p < 400) return CMD_READ;
    if (p < 750) return CMD_WRITE;
    if (p < 995) return CMD_FETCH;
    return CMD_CLEAR;
  endfunction

  task automatic test_directed();
    logic [ADDR_W-1:0] base_a;
    base_a = 32'h0012_3440;
    send_req(CMD_READ, 32'h0000_0000);
    send_req(CMD_READ, 32'h0000_003F);
    send_req(CMD_WRITE, 32'hFFFF_FFFF);
    send_req(CMD_WRITE, 32'hFFFF_FFC0);
    send_req(CMD_FETCH, 32'hFFFF_FFFF);
    send_req(CMD_FETCH, 32'hFFFF_FFC1);
    // Fill one data set with dirty lines, refresh the oldest, then evict
    for (int i = 0; i < 4; i++) send_req(CMD_WRITE, base_a + (i << 20));
    send_req(CMD_READ, base_a);
    send_req(CMD_READ, base_a + (4 << 20));
    send_req(CMD_READ, base_a + (5 << 20));
    send_req(CMD_READ, base_a + (1 << 20));
    // Instruction set: two ways, third fetch evicts the older line
    for (int i = 0; i < 3; i++) send_req(CMD_FETCH, base_a + (i << 20));
    send_req(CMD_FETCH, base_a + (2 << 20));
    // Clear drops lines and counters; same address misses again
    send_req(CMD_CLEAR, 32'hDEAD_BEEF);
    send_req(CMD_READ, base_a);
    send_req(CMD_FETCH, base_a);
    wait_drained();
  endtask

  task automatic test_random(int count, int idle, int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) send_req(pick_cmd(), pick_addr());
    wait_drained();
  endtask

  // Hold the receiver long while the sender pushes until the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 150;
    for (int i = 0; i < 30; i++) send_req(2'($urandom_range(2)), pick_addr());
    wait_drained();
  endtask

  // Stop sending until every result is back, then resume
  task automatic test_drain_pause();
    send_idle_pct = 10;
    stall_pct = 30;
    for (int i = 0; i < 20; i++) send_req(2'($urandom_range(2)), pick_addr());
    wait_drained();
    for (int i = 0; i < 20; i++) send_req(2'($urandom_range(2)), pick_addr());
    wait_drained();
  endtask

  // Drive the result stall: random, or a counted hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endfunction

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsp.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual %h", $time, rsp);
      end else begin
        e = expected_rsp.pop_front();
        check_field("hit", e.hit, rsp.hit);
        check_field("l2_read", e.l2_read, rsp.l2_read);
        check_field("writeback", e.writeback, rsp.writeback);
        check_field("writeback_address", e.writeback_address, rsp.writeback_address);
        check_field("data_hits", e.data_hits, rsp.data_hits);
        check_field("data_misses", e.data_misses, rsp.data_misses);
        check_field("data_reads", e.data_reads, rsp.data_reads);
        check_field("data_writes", e.data_writes, rsp.data_writes);
        check_field("instr_hits", e.instr_hits, rsp.instr_hits);
        check_field("instr_misses", e.instr_misses, rsp.instr_misses);
        check_field("instr_reads", e.instr_reads, rsp.instr_reads);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    for (int i = 0; i < 6; i++) tag_hi_pool[i] = 12'($urandom);
    for (int i = 0; i < 3; i++) set_pool[i] = SET_W'($urandom);
    model_clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(165, 0, 0);
    test_random(165, 58, 0);
    test_random(165, 0, 58);
    test_random(165, 29, 29);
    test_backpressure();
    test_drain_pause();
    repeat (20) @(posedge clk);
    if (errors == 0 && expected_rsp.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
